/* design/hit_volume_bucket_linker_defines.svh */
// Assertion macros for the hit volume bucket linker.
// Taken in by the modules that carry concurrent checks; no other dependencies.
`ifndef HIT_VOLUME_BUCKET_LINKER_DEFINES_SVH
`define HIT_VOLUME_BUCKET_LINKER_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define HVBL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define HVBL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/hvbl_pkg.sv */
// Shared constants for the hit volume bucket linker.
// No dependencies; imported by the top level, the checker and the testbench top.
package hvbl_pkg;

  // Table sizes and hit store size
  localparam int unsigned MAX_HITS     = 16384;
  localparam int unsigned VOLUME_DEPTH = 32768;
  localparam int unsigned ROW_DEPTH    = 64;

  // Field widths fixed by the item layout
  localparam int unsigned ID_W   = 14;
  localparam int unsigned ROW_W  = 6;
  localparam int unsigned BIN_W  = 8;
  localparam int unsigned CFG_W  = 6;
  localparam int unsigned VOL_W  = 15;
  localparam int unsigned STAT_W = 2;

  // Derived address and arithmetic widths
  localparam int unsigned VOL_AW    = $clog2(VOLUME_DEPTH);
  localparam int unsigned ROW_AW    = $clog2(ROW_DEPTH);
  localparam int unsigned PROD_W    = 2 * (CFG_W + 1);
  localparam int unsigned VOL_SUM_W = ROW_AW + PROD_W + 2;

  // Configuration register indexes
  localparam logic [1:0] CFG_PHI_BINS      = 2'd0;
  localparam logic [1:0] CFG_ETA_BINS      = 2'd1;
  localparam logic [1:0] CFG_INNERMOST_ROW = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_BIN_OUT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_REJECTED = 2'd2;
  localparam logic [STAT_W-1:0] ST_CLEARED  = 2'd3;

endpackage

/* design/hvbl_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module hvbl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds between reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/hit_volume_bucket_linker.sv */
// Hit volume bucket linker: appends each accepted hit to the tail of its volume list and its
// row list and reports the previous tails. An insert item passes through index arithmetic,
// volume compute with table read and write-back before its result is presented, and the next
// item is taken only once write-back is done; the two chained multiplications are split over
// the index and volume steps, and a stalled output holds the item in write-back. An item that
// fails a check skips write-back and hands over its status from the emit state. A clear item,
// and reset, walk the 32768-entry volume tail memory one entry per cycle while input is held
// off; a clear item then hands over its result, which holds input off until the output slot
// is free. Configuration writes are taken at any time but belong in idle periods.
module hit_volume_bucket_linker
  import hvbl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [5:0]  cfg_wdata_i,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // hit_id[13:0], hit_row[19:14], phi_bin[27:20],
                                     // eta_bin[35:28], zero fill
  input  logic        s_axis_tuser,  // mode
  // Result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // volume_slot[14:0], local_row[20:15],
                                     // volume_list_was_empty[21], volume_prev_hit[35:22],
                                     // row_list_was_empty[36], row_prev_hit[50:37], zero fill
  output logic [1:0]  m_axis_tuser   // status
);

  `include "hit_volume_bucket_linker_defines.svh"

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_IDX   = 3'd2;
  localparam logic [2:0] S_VOL   = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  localparam logic [VOL_AW-1:0] CLR_LAST = VOL_AW'(VOLUME_DEPTH - 1);

  logic [2:0]  state_q, state_d;
  logic [VOL_AW-1:0] clr_q, clr_d;
  logic        clr_emit_q, clr_emit_d;
  logic [ROW_DEPTH-1:0] row_vld_q, row_vld_d;

  logic [CFG_W-1:0] phi_bins_q, eta_bins_q, inner_row_q;

  logic [ID_W-1:0]  id_q;
  logic [ROW_W-1:0] row_q;
  logic signed [BIN_W-1:0] phi_q, eta_q;

  logic              bin_ok_q, row_ok_q;
  logic [ROW_AW-1:0] lrow_q;
  logic [PROD_W-1:0] p1_q, p2_q;
  logic [STAT_W-1:0] st_q;

  logic              m_valid_q, m_valid_d;
  logic [STAT_W-1:0] m_status_q;
  logic [55:0]       m_data_q;

  logic s_accept, out_free;

  // Index stage combinational terms
  logic signed [BIN_W-1:0] phi_max, eta_max, lrow_s;
  logic              bin_ok, row_ok;
  logic [CFG_W:0]    nphi1, neta1;

  // Volume stage combinational terms
  logic [VOL_SUM_W-1:0] vol_sum;
  logic                 vol_ok, insert_ok;

  // Memory ports
  logic              vol_we, vol_re, row_we;
  logic [VOL_AW-1:0] vol_waddr;
  logic [VOL_W-1:0]  vol_wdata, vol_rdata;
  logic [ID_W-1:0]   row_rdata;

  // Write-back result fields
  logic            vol_was_empty, row_was_empty;
  logic [ID_W-1:0] vol_prev, row_prev;
  logic            commit;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid & s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phi_bins_q  <= CFG_W'(10);
      eta_bins_q  <= CFG_W'(40);
      inner_row_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PHI_BINS:      phi_bins_q  <= cfg_wdata_i;
        CFG_ETA_BINS:      eta_bins_q  <= cfg_wdata_i;
        CFG_INNERMOST_ROW: inner_row_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Bin checks, local row and id checks, and the incremented bin counts for the partial products
  always_comb begin
    phi_max = $signed({2'b00, phi_bins_q});
    eta_max = $signed({2'b00, eta_bins_q});
    bin_ok  = (phi_q >= 8'sd1) && (phi_q <= phi_max) && (eta_q >= 8'sd1) && (eta_q <= eta_max);
    lrow_s  = $signed({2'b00, row_q}) - $signed({2'b00, inner_row_q}) + 8'sd1;
    row_ok  = (lrow_s >= 8'sd0) && (32'(lrow_s) < ROW_DEPTH) && (32'(id_q) < MAX_HITS);
    nphi1   = {1'b0, phi_bins_q} + (CFG_W + 1)'(1);
    neta1   = {1'b0, eta_bins_q} + (CFG_W + 1)'(1);
  end

  // Volume index from the registered products
  always_comb begin
    vol_sum   = VOL_SUM_W'(lrow_q) * VOL_SUM_W'(p1_q) + VOL_SUM_W'(p2_q)
              + VOL_SUM_W'(eta_q[CFG_W-1:0]);
    vol_ok    = 32'(vol_sum) < VOLUME_DEPTH;
    insert_ok = bin_ok_q && row_ok_q && vol_ok;
  end

  // Tail lookups and write-back data
  always_comb begin
    vol_was_empty = !vol_rdata[VOL_W-1];
    vol_prev      = vol_rdata[VOL_W-1] ? vol_rdata[ID_W-1:0] : '0;
    row_was_empty = !row_vld_q[lrow_q];
    row_prev      = row_vld_q[lrow_q] ? row_rdata : '0;
    commit        = (state_q == S_WB) && out_free;
    vol_re        = (state_q == S_VOL) && insert_ok;
    row_we        = commit;
    vol_we        = commit || (state_q == S_CLEAR);
    vol_waddr     = (state_q == S_CLEAR) ? clr_q : vol_sum[VOL_AW-1:0];
    vol_wdata     = (state_q == S_CLEAR) ? '0 : {1'b1, id_q};
  end

  // Sequencer: clearing pass, index stages, write-back, result hand-over
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    clr_emit_d = clr_emit_q;
    row_vld_d  = row_vld_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + VOL_AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = clr_emit_q ? S_EMIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_accept) begin
          if (s_axis_tuser) begin
            row_vld_d  = '0;
            clr_d      = '0;
            clr_emit_d = 1'b1;
            state_d    = S_CLEAR;
          end else begin
            state_d = S_IDX;
          end
        end
      end
      S_IDX: begin
        state_d = S_VOL;
      end
      S_VOL: begin
        state_d = insert_ok ? S_WB : S_EMIT;
      end
      S_WB: begin
        if (out_free) begin
          row_vld_d[lrow_q] = 1'b1;
          m_valid_d         = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          clr_emit_d = 1'b0;
          m_valid_d  = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      clr_emit_q <= 1'b0;
      row_vld_q  <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      clr_emit_q <= clr_emit_d;
      row_vld_q  <= row_vld_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Payload registers of the index pipeline and the output slot
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      id_q  <= s_axis_tdata[13:0];
      row_q <= s_axis_tdata[19:14];
      phi_q <= $signed(s_axis_tdata[27:20]);
      eta_q <= $signed(s_axis_tdata[35:28]);
    end
    if (state_q == S_IDX) begin
      bin_ok_q <= bin_ok;
      row_ok_q <= row_ok;
      lrow_q   <= lrow_s[ROW_AW-1:0];
      p1_q     <= PROD_W'(nphi1) * PROD_W'(neta1);
      p2_q     <= PROD_W'(phi_q[CFG_W-1:0]) * PROD_W'(neta1);
    end
    if (state_q == S_VOL) begin
      st_q <= bin_ok_q ? ST_REJECTED : ST_BIN_OUT;
    end
    if (state_q == S_CLEAR) begin
      st_q <= ST_CLEARED;
    end
    if (commit) begin
      m_status_q <= ST_INSERTED;
      m_data_q   <= {5'd0, row_prev, row_was_empty, vol_prev, vol_was_empty,
                     lrow_q, vol_sum[VOL_AW-1:0]};
    end else if ((state_q == S_EMIT) && out_free) begin
      m_status_q <= st_q;
      m_data_q   <= '0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_status_q;

  // Volume tail memory: valid bit over hit id
  hvbl_ram #(
    .WIDTH (VOL_W),
    .DEPTH (VOLUME_DEPTH)
  ) u_vol_ram (
    .clk_i   (clk_i),
    .we_i    (vol_we),
    .waddr_i (vol_waddr),
    .wdata_i (vol_wdata),
    .re_i    (vol_re),
    .raddr_i (vol_sum[VOL_AW-1:0]),
    .rdata_o (vol_rdata)
  );

  // Row tail memory: hit id only, validity lives in row_vld_q
  hvbl_ram #(
    .WIDTH (ID_W),
    .DEPTH (ROW_DEPTH)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (lrow_q),
    .wdata_i (id_q),
    .re_i    (vol_re),
    .raddr_i (lrow_q),
    .rdata_o (row_rdata)
  );

  `HVBL_ASSERT_NOW(a_no_read_on_write, vol_we, !vol_re, "volume memory read and written at once")
  `HVBL_ASSERT_NEXT(a_clear_starts, s_accept && s_axis_tuser,
                    (state_q == S_CLEAR) && (clr_q == '0) && (row_vld_q == '0),
                    "clear item did not start a clearing pass")
  `HVBL_ASSERT_NEXT(a_commit_emits, commit,
                    m_axis_tvalid && (m_axis_tuser == ST_INSERTED) && (state_q == S_IDLE),
                    "write-back did not hand over an insert result")
  `HVBL_ASSERT_NOW(a_clear_blocks_input, (state_q == S_CLEAR) || (state_q == S_WB),
                   !s_axis_tready, "input taken while tables busy")

endmodule

/* tb/hit_link_checker.sv */
`timescale 1ns / 100ps
// Checker for the hit volume bucket linker: watches the configuration port and both item
// channels, predicts every result and compares it field by field. Depends on hvbl_pkg only.
module hit_link_checker
  import hvbl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VOL_W-1:0]  volume_slot;
    logic [ROW_W-1:0]  local_row;
    logic              vol_empty;
    logic [ID_W-1:0]   vol_prev;
    logic              row_empty;
    logic [ID_W-1:0]   row_prev;
  } link_result_t;

  // Tail tables of the model: a live bit and the tail hit id per list
  bit              vol_live [VOLUME_DEPTH];
  bit [ID_W-1:0]   vol_tail [VOLUME_DEPTH];
  bit              row_live [ROW_DEPTH];
  bit [ID_W-1:0]   row_tail [ROW_DEPTH];
  logic [CFG_W-1:0] phi_n;
  logic [CFG_W-1:0] eta_n;
  logic [CFG_W-1:0] inner_row;

  link_result_t pending_links [$];
  int           fails;

  // Empty every volume and row list
  function automatic void wipe_lists();
    for (int i = 0; i < VOLUME_DEPTH; i++) vol_live[i] = 1'b0;
    for (int i = 0; i < ROW_DEPTH; i++) row_live[i] = 1'b0;
  endfunction

  // Work out the result of one hit or clear item and update the tail tables
  function automatic link_result_t link_hit(input logic mode,
                                            input logic [ID_W-1:0] id,
                                            input logic [ROW_W-1:0] row,
                                            input logic signed [BIN_W-1:0] phi,
                                            input logic signed [BIN_W-1:0] eta);
    link_result_t res;
    int p, e, np, ne, lrow, vol, rowi, idi;
    res  = '0;
    p    = phi;
    e    = eta;
    np   = phi_n;
    ne   = eta_n;
    rowi = row;
    idi  = id;
    if (mode) begin
      wipe_lists();
      res.status = ST_CLEARED;
      return res;
    end
    // Bin range check comes first
    if (p < 1 || p > np || e < 1 || e > ne) begin
      res.status = ST_BIN_OUT;
      return res;
    end
    lrow = rowi - int'(inner_row) + 1;
    vol  = lrow * (np + 1) * (ne + 1) + p * (ne + 1) + e;
    if (lrow < 0 || lrow >= int'(ROW_DEPTH) || vol < 0 || vol >= int'(VOLUME_DEPTH) ||
        idi >= int'(MAX_HITS)) begin
      res.status = ST_REJECTED;
      return res;
    end
    res.status      = ST_INSERTED;
    res.volume_slot = vol[VOL_W-1:0];
    res.local_row   = lrow[ROW_W-1:0];
    res.vol_empty   = !vol_live[vol];
    res.vol_prev    = vol_live[vol] ? vol_tail[vol] : '0;
    res.row_empty   = !row_live[lrow];
    res.row_prev    = row_live[lrow] ? row_tail[lrow] : '0;
    vol_live[vol]   = 1'b1;
    vol_tail[vol]   = id;
    row_live[lrow]  = 1'b1;
    row_tail[lrow]  = id;
    return res;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // Track configuration, predict on each accepted input item, compare on each result item
  always @(posedge clk_i or negedge rst_ni) begin : watch
    link_result_t want;
    link_result_t got;
    if (!rst_ni) begin
      wipe_lists();
      phi_n     = 6'd10;
      eta_n     = 6'd40;
      inner_row = 6'd1;
      pending_links.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PHI_BINS:      phi_n = cfg_wdata_i;
          CFG_ETA_BINS:      eta_n = cfg_wdata_i;
          CFG_INNERMOST_ROW: inner_row = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_links.push_back(link_hit(s_axis_tuser, s_axis_tdata[13:0],
                                         s_axis_tdata[19:14], s_axis_tdata[27:20],
                                         s_axis_tdata[35:28]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_links.size() == 0) begin
          $error("result item with no expectation waiting");
          fails++;
        end else begin
          want = pending_links.pop_front();
          got.status      = m_axis_tuser;
          got.volume_slot = m_axis_tdata[14:0];
          got.local_row   = m_axis_tdata[20:15];
          got.vol_empty   = m_axis_tdata[21];
          got.vol_prev    = m_axis_tdata[35:22];
          got.row_empty   = m_axis_tdata[36];
          got.row_prev    = m_axis_tdata[50:37];
          check_field("status", want.status, got.status);
          check_field("volume_slot", want.volume_slot, got.volume_slot);
          check_field("local_row", want.local_row, got.local_row);
          check_field("volume_list_was_empty", want.vol_empty, got.vol_empty);
          check_field("volume_prev_hit", want.vol_prev, got.vol_prev);
          check_field("row_list_was_empty", want.row_empty, got.row_empty);
          check_field("row_prev_hit", want.row_prev, got.row_prev);
        end
      end
      fail_count_o <= fails;
      pending_o    <= pending_links.size();
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Top of the hit volume bucket linker testbench: clock, reset, configuration phases and
// stimulus with random idling, plus the verdict. Depends on hvbl_pkg, hit_link_checker and the linker.
module tb
  import hvbl_pkg::*;
();

  localparam int LIMIT = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_PHI_BINS;
  logic [5:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // hit_id, hit_row, phi_bin, eta_bin, zero fill
  logic        s_axis_tuser = 1'b0;  // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;  // volume_slot, local_row, volume_list_was_empty,
                              // volume_prev_hit, row_list_was_empty, row_prev_hit
  logic [1:0]  m_axis_tuser;  // status

  int fail_count;
  int pending;
  int cycles = 0;

  // Current register values as the stimulus sees them
  int  cur_phi, cur_eta, cur_inner;
  int  clears_left = 6;
  bit  quiet_send = 1'b0;
  logic hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  stall_left = 0;
  int  calm_left = 0;

  hit_volume_bucket_linker dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  hit_link_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Gap length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 16);
    else return $urandom_range(17, 60);
  endfunction

  // Result side: random stalls, calm stretches and one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin : result_ready
    int r;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      stall_left = 400;
      hold_done  = 1'b1;
    end else if (calm_left > 0) begin
      m_axis_tready <= 1'b1;
      calm_left = calm_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        m_axis_tready <= 1'b1;
      end else if (r < 80) begin
        m_axis_tready <= 1'b1;
        calm_left = $urandom_range(50, 200);
      end else begin
        m_axis_tready <= 1'b0;
        stall_left = gap_len() - 1;
      end
    end
  end

  // Stop a hung run
  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Offer one item, after an optional gap, and hold it until accepted
  task automatic send_item(input logic mode, input logic [ID_W-1:0] id,
                           input logic [ROW_W-1:0] row, input logic [BIN_W-1:0] phi,
                           input logic [BIN_W-1:0] eta);
    int gap;
    gap = 0;
    if (!quiet_send && $urandom_range(0, 99) < 35) gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {4'b0, eta, phi, row, id};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic insert_hit(input int id, input int row, input int phi, input int eta);
    send_item(1'b0, id[ID_W-1:0], row[ROW_W-1:0], phi[BIN_W-1:0], eta[BIN_W-1:0]);
  endtask

  // Write all three registers on consecutive cycles
  task automatic set_config(input int phi, input int eta, input int inner);
    cur_phi   = phi;
    cur_eta   = eta;
    cur_inner = inner;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_PHI_BINS;
    cfg_wdata_i <= phi[5:0];
    @(posedge clk_i);
    cfg_idx_i   <= CFG_ETA_BINS;
    cfg_wdata_i <= eta[5:0];
    @(posedge clk_i);
    cfg_idx_i   <= CFG_INNERMOST_ROW;
    cfg_wdata_i <= inner[5:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid and wait until every expected result has arrived
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Random item: mostly well-formed hits on a few lists, some noise, rare clears
  task automatic send_random();
    int r, phi, eta, lrow, row;
    r = $urandom_range(0, 999);
    if (r < 10 && clears_left > 0) begin
      clears_left--;
      send_item(1'b1, ID_W'($urandom), ROW_W'($urandom), BIN_W'($urandom),
                BIN_W'($urandom));
    end else if (r < 820 && cur_phi >= 1 && cur_eta >= 1) begin
      r   = $urandom_range(0, 99);
      phi = (r < 40) ? 1 : (r < 60) ? cur_phi : $urandom_range(1, cur_phi);
      r   = $urandom_range(0, 99);
      eta = (r < 40) ? 1 : (r < 60) ? cur_eta : $urandom_range(1, cur_eta);
      lrow = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3) : $urandom_range(0, 63);
      row  = (cur_inner + lrow - 1) & 63;
      insert_hit($urandom_range(0, 16383), row, phi, eta);
    end else begin
      insert_hit($urandom_range(0, 16383), $urandom_range(0, 63), $urandom_range(0, 255),
                 $urandom_range(0, 255));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: register defaults, list heads and tails, bin edges, clear
    set_config(10, 40, 1);
    insert_hit(0, 1, 1, 1);
    insert_hit(16383, 1, 1, 1);
    insert_hit(5, 1, 10, 40);
    insert_hit(100, 0, 1, 1);
    insert_hit(200, 63, 10, 40);
    insert_hit(1, 1, 0, 1);
    insert_hit(2, 1, 11, 1);
    insert_hit(3, 1, 8'h80, 1);
    insert_hit(4, 1, 8'h7f, 1);
    insert_hit(6, 1, 1, 0);
    insert_hit(8, 1, 1, 41);
    insert_hit(9, 1, 1, 8'hff);
    send_item(1'b1, '0, '0, '0, '0);
    insert_hit(7, 1, 1, 1);
    insert_hit(14'h2aaa, 6'h2a, 10, 40);
    wait_quiet();

    // Directed: row beyond the table, largest volume, volume beyond the table
    set_config(63, 63, 0);
    insert_hit(11, 63, 1, 1);
    insert_hit(12, 6, 63, 63);
    insert_hit(13, 7, 63, 63);
    insert_hit(14, 0, 63, 1);
    wait_quiet();

    // Directed: negative local row
    set_config(5, 5, 63);
    insert_hit(15, 0, 3, 3);
    insert_hit(16, 63, 5, 5);
    wait_quiet();

    // Directed: zero bin counts drop everything
    set_config(0, 0, 0);
    insert_hit(17, 1, 1, 1);
    insert_hit(18, 1, 0, 0);
    wait_quiet();

    // Random phases over several settings
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_config(63, 63, 0);
        1: set_config(1, 1, 63);
        2: set_config(63, 1, 20);
        3: set_config(1, 63, 5);
        default: set_config($urandom_range(1, 63), $urandom_range(1, 63),
                            $urandom_range(0, 63));
      endcase
      quiet_send = (ph == 3);
      if (ph == 0) hold_req <= 1'b1;
      for (int n = 0; n < 100; n++) send_random();
      wait_quiet();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
